@@ hw/rtl/rpc_frame_deframer_assert.svh @@
// Assertion macros for the RPC frame deframer.
// Taken in by the files that check their own logic; needs nothing else.
`ifndef RPC_FRAME_DEFRAMER_ASSERT_SVH
`define RPC_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, off during reset
`define RPCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpc deframer check failed");

// Next-cycle implication, off during reset
`define RPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpc deframer check failed");

`endif

@@ hw/rtl/rpcd_pkg.sv @@
// Shared types and constants of the RPC frame deframer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rpcd_pkg;

    // Defaults and fixed sizes
    localparam int LEN_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FIXED_OVERHEAD  = 26;
    localparam int FRAME_LEN_W     = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    // Register reset values
    localparam logic [7:0]  START_MARKER_RST  = 8'h02;
    localparam logic [7:0]  END_MARKER_RST    = 8'h03;
    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'hFFFF;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER  = 2'd0,
        CFG_END_MARKER    = 2'd1,
        CFG_MAX_FRAME_LEN = 2'd2
    } t_cfg_idx;

    // Section tags
    localparam logic [2:0] SEC_MSG_ID   = 3'd0;
    localparam logic [2:0] SEC_SERVICE  = 3'd1;
    localparam logic [2:0] SEC_ERR_INFO = 3'd2;
    localparam logic [2:0] SEC_PAYLOAD  = 3'd3;
    localparam logic [2:0] SEC_STATUS   = 3'd4;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_END   = 3'd1;
    localparam logic [2:0] ST_EMPTY_ID  = 3'd2;
    localparam logic [2:0] ST_NAME_LONG = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;

    // Framing phase of the front
    typedef enum logic [1:0] {
        FP_HUNT,
        FP_FLEN,
        FP_BODY
    } t_front_ph;

    // Field walker phase of the back
    typedef enum logic [3:0] {
        WP_MLEN,
        WP_MID,
        WP_NLEN,
        WP_NAME,
        WP_ECODE,
        WP_ELEN,
        WP_EINFO,
        WP_PAY,
        WP_SKIP
    } t_walk_ph;

    // Token kinds passed from front to back
    typedef enum logic [1:0] {
        TK_BODY,
        TK_START,
        TK_END,
        TK_BADLEN
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic        bad_end;
        logic [7:0]  data;
        logic [15:0] len;
    } t_tok;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] max_frame_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  section;
        logic [2:0]  status;
        logic [31:0] error_code;
        logic [15:0] frame_len;
        logic        last;
    } t_res;

endpackage

`default_nettype wire

@@ hw/rtl/rpcd_front.sv @@
// Front of the RPC frame deframer: hunts for frames, reads the length header
// and tags each frame byte as a token for the back. Depends on rpcd_pkg.
`default_nettype none

module rpcd_front #(
    parameter int LEN_BITS = rpcd_pkg::LEN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpcd_pkg::t_cfg i_cfg,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output logic           o_push,
    output rpcd_pkg::t_tok o_tok
);
    import rpcd_pkg::*;

    localparam int FL_W = (LEN_BITS < FRAME_LEN_W) ? LEN_BITS : FRAME_LEN_W;

    t_front_ph       r_ph, n_ph;
    logic [FL_W-1:0] r_pos, n_pos;
    logic [FL_W-1:0] r_flen, n_flen;
    logic [1:0]      r_wcnt, n_wcnt;
    logic [31:0]     r_acc, n_acc;

    logic [31:0] w_acc;
    logic        w_len_bad;
    logic        w_last;
    logic        w_word_done;

    // Shift the byte into the header word and judge the length
    assign w_acc       = {r_acc[23:0], i_byte};
    assign w_word_done = (r_wcnt == 2'd3);
    assign w_len_bad   = (w_acc < 32'(FIXED_OVERHEAD))
                      || (w_acc > {16'd0, i_cfg.max_frame_len})
                      || (({32'd0, w_acc} >> LEN_BITS) != 64'd0);
    assign w_last      = (({1'b0, r_pos} + (FL_W+1)'(1)) == {1'b0, r_flen});

    // Next phase
    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            FP_HUNT: begin
                if (i_accept && (i_byte == i_cfg.start_marker)) begin
                    n_ph = FP_FLEN;
                end
            end
            FP_FLEN: begin
                if (i_accept && w_word_done) begin
                    n_ph = w_len_bad ? FP_HUNT : FP_BODY;
                end
            end
            FP_BODY: begin
                if (i_accept && w_last) begin
                    n_ph = FP_HUNT;
                end
            end
            default: n_ph = FP_HUNT;
        endcase
    end

    // Token out
    always_comb begin
        o_push        = 1'b0;
        o_tok.kind    = TK_BODY;
        o_tok.bad_end = (i_byte != i_cfg.end_marker);
        o_tok.data    = i_byte;
        o_tok.len     = w_acc[15:0];
        case (r_ph)
            FP_FLEN: begin
                if (i_accept && w_word_done) begin
                    o_push     = 1'b1;
                    o_tok.kind = w_len_bad ? TK_BADLEN : TK_START;
                end
            end
            FP_BODY: begin
                if (i_accept) begin
                    o_push     = 1'b1;
                    o_tok.kind = w_last ? TK_END : TK_BODY;
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    // Position, header word and frame length
    always_comb begin
        n_pos  = r_pos;
        n_flen = r_flen;
        n_wcnt = r_wcnt;
        n_acc  = r_acc;
        if (i_accept) begin
            case (r_ph)
                FP_HUNT: begin
                    if (i_byte == i_cfg.start_marker) begin
                        n_pos  = FL_W'(1);
                        n_wcnt = 2'd0;
                        n_acc  = 32'd0;
                    end else begin
                        n_pos  = '0;
                    end
                end
                FP_FLEN: begin
                    n_acc  = w_acc;
                    n_wcnt = r_wcnt + 2'd1;
                    n_pos  = r_pos + FL_W'(1);
                    if (w_word_done) begin
                        if (w_len_bad) begin
                            n_pos = '0;
                        end else begin
                            n_flen = w_acc[FL_W-1:0];
                        end
                    end
                end
                FP_BODY: begin
                    n_pos = w_last ? '0 : r_pos + FL_W'(1);
                end
                default: n_pos = '0;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= FP_HUNT;
            r_pos  <= '0;
            r_wcnt <= 2'd0;
        end else begin
            r_ph   <= n_ph;
            r_pos  <= n_pos;
            r_wcnt <= n_wcnt;
        end
    end

    // Header payload registers
    always_ff @(posedge i_clk) begin
        r_flen <= n_flen;
        r_acc  <= n_acc;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rpcd_queue.sv @@
// Short token queue between front and back of the RPC frame deframer.
// Flop-based, one push and one pop per cycle. Depends on rpcd_pkg only for defaults.
`default_nettype none

module rpcd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rpcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    // Advance pointers with wrap, track fill
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rpcd_back.sv @@
// Back of the RPC frame deframer: walks the frame fields from the token
// stream, emits content and status results into an output register. Depends on rpcd_pkg.
`default_nettype none

module rpcd_back #(
    parameter int LEN_BITS = rpcd_pkg::LEN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    input  rpcd_pkg::t_tok i_tok,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output rpcd_pkg::t_res o_res
);
    import rpcd_pkg::*;

    localparam int FL_W = (LEN_BITS < FRAME_LEN_W) ? LEN_BITS : FRAME_LEN_W;

    t_walk_ph        r_wph, n_wph;
    logic [1:0]      r_wcnt, n_wcnt;
    logic [31:0]     r_wacc, n_wacc;
    logic [FL_W-1:0] r_frem, n_frem;
    logic [FL_W-1:0] r_prem, n_prem;
    logic [FL_W-1:0] r_flen, n_flen;
    logic [2:0]      r_pend, n_pend;
    logic [31:0]     r_held, n_held;
    logic            r_out_valid;
    t_res            r_res;

    logic            w_out_free;
    logic            w_body;
    logic            w_emit;
    t_res            w_res;
    logic [31:0]     w_nacc;
    logic [FL_W-1:0] w_nacc_fl;
    logic            w_done;
    logic            w_nacc_zero;
    logic            w_gt_prem;
    logic            w_gt_flen;
    logic [FL_W-1:0] w_prem_sub;
    logic            w_frem_last;
    logic            w_prem_last;

    // Take a token whenever the output register can hold a result
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_pop       = i_tok_valid && w_out_free;
    assign w_body      = o_pop && (i_tok.kind == TK_BODY);

    assign w_nacc      = {r_wacc[23:0], i_tok.data};
    assign w_nacc_fl   = w_nacc[FL_W-1:0];
    assign w_done      = (r_wcnt == 2'd3);
    assign w_nacc_zero = (w_nacc == 32'd0);
    assign w_gt_prem   = (w_nacc > 32'(r_prem));
    assign w_gt_flen   = (w_nacc > 32'(r_flen));
    assign w_prem_sub  = r_prem - w_nacc_fl;
    assign w_frem_last = (r_frem[FL_W-1:1] == '0);
    assign w_prem_last = (r_prem[FL_W-1:1] == '0);

    // Next walker phase
    always_comb begin
        n_wph = r_wph;
        if (o_pop && (i_tok.kind == TK_START)) begin
            n_wph = WP_MLEN;
        end else if (w_body) begin
            case (r_wph)
                WP_MLEN: begin
                    if (w_done) begin
                        n_wph = (w_nacc_zero || w_gt_prem) ? WP_SKIP : WP_MID;
                    end
                end
                WP_MID: begin
                    if (w_frem_last) begin
                        n_wph = WP_NLEN;
                    end
                end
                WP_NLEN: begin
                    if (w_done) begin
                        if (w_gt_flen || w_gt_prem) begin
                            n_wph = WP_SKIP;
                        end else begin
                            n_wph = w_nacc_zero ? WP_ECODE : WP_NAME;
                        end
                    end
                end
                WP_NAME: begin
                    if (w_frem_last) begin
                        n_wph = WP_ECODE;
                    end
                end
                WP_ECODE: begin
                    if (w_done) begin
                        n_wph = WP_ELEN;
                    end
                end
                WP_ELEN: begin
                    if (w_done) begin
                        if (w_gt_prem) begin
                            n_wph = WP_SKIP;
                        end else if (w_nacc_zero) begin
                            n_wph = (w_prem_sub == '0) ? WP_SKIP : WP_PAY;
                        end else begin
                            n_wph = WP_EINFO;
                        end
                    end
                end
                WP_EINFO: begin
                    if (w_frem_last) begin
                        n_wph = (r_prem == '0) ? WP_SKIP : WP_PAY;
                    end
                end
                WP_PAY: begin
                    if (w_prem_last) begin
                        n_wph = WP_SKIP;
                    end
                end
                WP_SKIP: n_wph = WP_SKIP;
                default: n_wph = WP_SKIP;
            endcase
        end
    end

    // Result for the current token
    always_comb begin
        w_emit           = 1'b0;
        w_res.data_byte  = i_tok.data;
        w_res.section    = SEC_MSG_ID;
        w_res.status     = ST_OK;
        w_res.error_code = 32'd0;
        w_res.frame_len  = 16'd0;
        w_res.last       = 1'b0;
        if (o_pop) begin
            case (i_tok.kind)
                TK_BODY: begin
                    case (r_wph)
                        WP_MID: begin
                            w_emit        = 1'b1;
                            w_res.section = SEC_MSG_ID;
                        end
                        WP_NAME: begin
                            w_emit        = 1'b1;
                            w_res.section = SEC_SERVICE;
                        end
                        WP_EINFO: begin
                            w_emit        = 1'b1;
                            w_res.section = SEC_ERR_INFO;
                        end
                        WP_PAY: begin
                            w_emit        = 1'b1;
                            w_res.section = SEC_PAYLOAD;
                        end
                        default: w_emit = 1'b0;
                    endcase
                end
                TK_END: begin
                    w_emit           = 1'b1;
                    w_res.data_byte  = 8'd0;
                    w_res.section    = SEC_STATUS;
                    w_res.status     = i_tok.bad_end ? ST_BAD_END : r_pend;
                    w_res.error_code = r_held;
                    w_res.frame_len  = FRAME_LEN_W'(r_flen);
                    w_res.last       = 1'b1;
                end
                TK_BADLEN: begin
                    w_emit          = 1'b1;
                    w_res.data_byte = 8'd0;
                    w_res.section   = SEC_STATUS;
                    w_res.status    = ST_BAD_LEN;
                    w_res.frame_len = i_tok.len;
                    w_res.last      = 1'b1;
                end
                default: w_emit = 1'b0;
            endcase
        end
    end

    // Field counters, held error code and pending status
    always_comb begin
        n_wcnt = r_wcnt;
        n_wacc = r_wacc;
        n_frem = r_frem;
        n_prem = r_prem;
        n_flen = r_flen;
        n_pend = r_pend;
        n_held = r_held;
        if (o_pop && (i_tok.kind == TK_START)) begin
            n_flen = i_tok.len[FL_W-1:0];
            n_prem = i_tok.len[FL_W-1:0] - FL_W'(FIXED_OVERHEAD);
            n_pend = ST_OK;
            n_held = 32'd0;
            n_wcnt = 2'd0;
            n_wacc = 32'd0;
        end else if (w_body) begin
            case (r_wph)
                WP_MLEN, WP_NLEN, WP_ECODE, WP_ELEN: begin
                    if (w_done) begin
                        n_wcnt = 2'd0;
                        n_wacc = 32'd0;
                    end else begin
                        n_wcnt = r_wcnt + 2'd1;
                        n_wacc = w_nacc;
                    end
                end
                default: n_wcnt = r_wcnt;
            endcase
            case (r_wph)
                WP_MLEN: begin
                    if (w_done) begin
                        if (w_nacc_zero) begin
                            n_pend = (r_pend == ST_OK) ? ST_EMPTY_ID : r_pend;
                        end else if (w_gt_prem) begin
                            n_pend = (r_pend == ST_OK) ? ST_BAD_LEN : r_pend;
                        end else begin
                            n_prem = w_prem_sub;
                            n_frem = w_nacc_fl;
                        end
                    end
                end
                WP_NLEN: begin
                    if (w_done) begin
                        if (w_gt_flen) begin
                            n_pend = (r_pend == ST_OK) ? ST_NAME_LONG : r_pend;
                        end else if (w_gt_prem) begin
                            n_pend = (r_pend == ST_OK) ? ST_BAD_LEN : r_pend;
                        end else begin
                            n_prem = w_prem_sub;
                            n_frem = w_nacc_fl;
                        end
                    end
                end
                WP_ECODE: begin
                    if (w_done) begin
                        n_held = w_nacc;
                    end
                end
                WP_ELEN: begin
                    if (w_done) begin
                        if (w_gt_prem) begin
                            n_pend = (r_pend == ST_OK) ? ST_BAD_LEN : r_pend;
                        end else begin
                            n_prem = w_prem_sub;
                            n_frem = w_nacc_fl;
                        end
                    end
                end
                WP_MID, WP_NAME, WP_EINFO: begin
                    n_frem = r_frem - FL_W'(1);
                end
                WP_PAY: begin
                    n_prem = r_prem - FL_W'(1);
                end
                default: n_frem = r_frem;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wph       <= WP_SKIP;
            r_wcnt      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_wph  <= n_wph;
            r_wcnt <= n_wcnt;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // Walker payload and result register
    always_ff @(posedge i_clk) begin
        r_wacc <= n_wacc;
        r_frem <= n_frem;
        r_prem <= n_prem;
        r_flen <= n_flen;
        r_pend <= n_pend;
        r_held <= n_held;
        if (w_emit) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/rpc_frame_deframer.sv @@
// Top level of the RPC frame deframer: configuration registers, front,
// token queue and back. Depends on rpcd_pkg, rpcd_front, rpcd_queue, rpcd_back.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    i_byte_in
//   out      from block o_out_valid / i_out_stall  o_data_byte o_section o_status
//                                                  o_error_code o_frame_len o_last
//   cfg      to block   i_cfg_we                   i_cfg_idx i_cfg_data
//
// One byte per cycle sustained while o_in_stall is low; the front parses each byte in the cycle it is taken.
// After its byte is taken, a result passes the queue write, then the output register.
// Input stalls only while the token queue is full, i.e. after the output has been
// stalled long enough to fill it. Synchronous active-low reset; no clearing pass.
`default_nettype none

module rpc_frame_deframer #(
    parameter int LEN_BITS    = rpcd_pkg::LEN_BITS_DEF,
    parameter int QUEUE_DEPTH = rpcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rpcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_byte_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_data_byte,
    output logic [2:0]                        o_section,
    output logic [2:0]                        o_status,
    output logic signed [31:0]                o_error_code,
    output logic [15:0]                       o_frame_len,
    output logic                              o_last
);
    import rpcd_pkg::*;

    t_cfg r_cfg;
    t_tok w_fr_tok;
    t_tok w_q_tok;
    t_res w_res;
    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    logic w_status_shape;
    logic w_content_shape;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker  <= START_MARKER_RST;
            r_cfg.end_marker    <= END_MARKER_RST;
            r_cfg.max_frame_len <= MAX_FRAME_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER:  r_cfg.start_marker  <= i_cfg_data[7:0];
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data[7:0];
                CFG_MAX_FRAME_LEN: r_cfg.max_frame_len <= i_cfg_data[15:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // Hold input while the queue is full
    assign o_in_stall = w_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    rpcd_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_byte   (i_byte_in),
        .o_push   (w_push),
        .o_tok    (w_fr_tok)
    );

    rpcd_queue #(
        .WIDTH (($bits(t_tok))),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fr_tok),
        .i_pop   (w_pop),
        .o_data  (w_q_tok),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    rpcd_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!w_q_empty),
        .i_tok       (w_q_tok),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    // Unpack the result register
    assign o_data_byte  = w_res.data_byte;
    assign o_section    = w_res.section;
    assign o_status     = w_res.status;
    assign o_error_code = $signed(w_res.error_code);
    assign o_frame_len  = w_res.frame_len;
    assign o_last       = w_res.last;

    // Shape of status and content results
    assign w_status_shape  = (o_section == SEC_STATUS) && (o_data_byte == 8'd0);
    assign w_content_shape = (o_section != SEC_STATUS) && (o_status == ST_OK)
                          && (o_frame_len == 16'd0);

    `include "rpc_frame_deframer_assert.svh"

    `RPCD_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_q_full)
    `RPCD_ASSERT_NEXT(a_empty_then_open, i_clk, i_rst_n, w_q_empty, !o_in_stall)
    `RPCD_ASSERT_IMPL(a_status_tagged, i_clk, i_rst_n, o_out_valid && o_last, w_status_shape)
    `RPCD_ASSERT_IMPL(a_content_clean, i_clk, i_rst_n, o_out_valid && !o_last, w_content_shape)

endmodule

`default_nettype wire
